// File: rtl/core/ecc_pkg.sv
// Shared types, constants and calendar helpers for the epoch calendar converter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ecc_pkg;

   // Request and response words
   typedef struct packed {
      logic        command;
      logic [31:0] epoch_in;
      logic [6:0]  year_in;
      logic [3:0]  month_in;
      logic [6:0]  day_in;
      logic [6:0]  hour_in;
      logic [6:0]  minute_in;
      logic [6:0]  second_in;
   } ecc_req_type;

   typedef struct packed {
      logic [31:0] epoch_out;
      logic [11:0] year_out;
      logic [3:0]  month_out;
      logic [4:0]  day_out;
      logic [4:0]  hour_out;
      logic [5:0]  minute_out;
      logic [5:0]  second_out;
      logic        month_error;
   } ecc_rsp_type;

   // Command codes of the request word
   localparam logic CMD_SPLIT = 1'b0;
   localparam logic CMD_BUILD = 1'b1;

   // Datapath operations issued by the controller
   localparam int OP_W = 4;
   typedef logic [OP_W-1:0] ecc_op_type;
   localparam ecc_op_type OP_NONE      = 4'd0;
   localparam ecc_op_type OP_SUB_YEAR  = 4'd1;
   localparam ecc_op_type OP_SUB_MONTH = 4'd2;
   localparam ecc_op_type OP_SUB_DAY   = 4'd3;
   localparam ecc_op_type OP_SUB_HOUR  = 4'd4;
   localparam ecc_op_type OP_SUB_MIN   = 4'd5;
   localparam ecc_op_type OP_ADD_YEAR  = 4'd6;
   localparam ecc_op_type OP_ADD_MONTH = 4'd7;
   localparam ecc_op_type OP_ADD_DAY   = 4'd8;
   localparam ecc_op_type OP_ADD_HOUR  = 4'd9;
   localparam ecc_op_type OP_ADD_MINSEC = 4'd10;

   typedef struct packed {
      logic       load_req;
      logic       load_rsp;
      ecc_op_type op;
   } ecc_cmd_type;

   typedef struct packed {
      logic is_build;
      logic month_ok;
      logic more;
   } ecc_status_type;

   // Time constants
   localparam logic [31:0] SECS_MIN  = 32'd60;
   localparam logic [31:0] SECS_HOUR = 32'd3600;
   localparam logic [31:0] SECS_DAY  = 32'd86400;
   localparam logic [31:0] SECS_YEAR = 32'd31536000;

   localparam logic [11:0] EPOCH_YEAR = 12'd1970;
   localparam logic [11:0] BASE_20XX  = 12'd2000;
   localparam logic [11:0] BASE_19XX  = 12'd1900;
   localparam logic [6:0]  YY_PIVOT   = 7'd70;
   localparam logic [11:0] NON_LEAP_CENTURY = 12'd2100;

   localparam logic [3:0] MONTH_FIRST = 4'd1;
   localparam logic [3:0] MONTH_LAST  = 4'd12;
   localparam logic [3:0] MONTH_FEB   = 4'd2;

   // Gregorian leap rule, exact for years 1901 to 2199
   function automatic logic is_leap(input logic [11:0] y);
      return (y[1:0] == 2'b00) && (y != NON_LEAP_CENTURY);
   endfunction

   // Length of a one-based month in seconds
   function automatic logic [31:0] month_len_secs(input logic [3:0] m, input logic leap);
      logic [31:0] s;
      case (m)
         4'd2:                s = leap ? 32'd2505600 : 32'd2419200;
         4'd4, 4'd6, 4'd9,
         4'd11:               s = 32'd2592000;
         default:             s = 32'd2678400;
      endcase
      return s;
   endfunction

   // Seconds from 1 January to the first of a one-based month, common year
   function automatic logic [31:0] month_start_secs(input logic [3:0] m);
      logic [31:0] s;
      case (m)
         4'd1:    s = 32'd0;
         4'd2:    s = 32'd2678400;
         4'd3:    s = 32'd5097600;
         4'd4:    s = 32'd7776000;
         4'd5:    s = 32'd10368000;
         4'd6:    s = 32'd13046400;
         4'd7:    s = 32'd15638400;
         4'd8:    s = 32'd18316800;
         4'd9:    s = 32'd20995200;
         4'd10:   s = 32'd23587200;
         4'd11:   s = 32'd26265600;
         4'd12:   s = 32'd28857600;
         default: s = 32'd0;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/ecc_ctrl.sv
// Sequencing state machine of the epoch calendar converter.
// Depends on ecc_pkg; drives ecc_dp through command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module ecc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  ecc_pkg::ecc_status_type status,
   output ecc_pkg::ecc_cmd_type    cmd
);
   import ecc_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_START   = 4'd1;
   localparam logic [3:0] S_SPLIT_Y = 4'd2;
   localparam logic [3:0] S_SPLIT_M = 4'd3;
   localparam logic [3:0] S_SPLIT_D = 4'd4;
   localparam logic [3:0] S_SPLIT_H = 4'd5;
   localparam logic [3:0] S_SPLIT_N = 4'd6;
   localparam logic [3:0] S_BUILD_Y = 4'd7;
   localparam logic [3:0] S_BUILD_M = 4'd8;
   localparam logic [3:0] S_BUILD_D = 4'd9;
   localparam logic [3:0] S_BUILD_H = 4'd10;
   localparam logic [3:0] S_BUILD_N = 4'd11;
   localparam logic [3:0] S_FINISH  = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.load_req = 1'b0;
      cmd.load_rsp = 1'b0;
      cmd.op       = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_START;
            end
         end
         S_START: begin
            if (!status.is_build) begin
               state_in = S_SPLIT_Y;
            end else if (status.month_ok) begin
               state_in = S_BUILD_Y;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SPLIT_Y: begin
            cmd.op = OP_SUB_YEAR;
            if (!status.more) state_in = S_SPLIT_M;
         end
         S_SPLIT_M: begin
            cmd.op = OP_SUB_MONTH;
            if (!status.more) state_in = S_SPLIT_D;
         end
         S_SPLIT_D: begin
            cmd.op = OP_SUB_DAY;
            if (!status.more) state_in = S_SPLIT_H;
         end
         S_SPLIT_H: begin
            cmd.op = OP_SUB_HOUR;
            if (!status.more) state_in = S_SPLIT_N;
         end
         S_SPLIT_N: begin
            cmd.op = OP_SUB_MIN;
            if (!status.more) state_in = S_FINISH;
         end
         S_BUILD_Y: begin
            cmd.op = OP_ADD_YEAR;
            if (!status.more) state_in = S_BUILD_M;
         end
         S_BUILD_M: begin
            cmd.op   = OP_ADD_MONTH;
            state_in = S_BUILD_D;
         end
         S_BUILD_D: begin
            cmd.op   = OP_ADD_DAY;
            state_in = S_BUILD_H;
         end
         S_BUILD_H: begin
            cmd.op   = OP_ADD_HOUR;
            state_in = S_BUILD_N;
         end
         S_BUILD_N: begin
            cmd.op   = OP_ADD_MINSEC;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/ecc_dp.sv
// Datapath of the epoch calendar converter: one 32-bit add/subtract accumulator
// with calendar counters and the response register. Depends on ecc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ecc_dp (
   input  logic                    clock,
   input  ecc_pkg::ecc_req_type    req_word,
   input  ecc_pkg::ecc_cmd_type    cmd,
   output ecc_pkg::ecc_status_type status,
   output ecc_pkg::ecc_rsp_type    rsp_word
);
   import ecc_pkg::*;

   ecc_req_type req_ff;
   ecc_rsp_type rsp_ff, rsp_in;
   logic [31:0] acc_ff, acc_in;
   logic [11:0] year_ff, year_in;
   logic [11:0] target_ff, target_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff, day_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;

   logic [31:0] operand;
   logic        ge;
   logic        more;
   logic        month_ok;
   logic        leap_cur;
   logic        leap_tgt;

   assign leap_cur = is_leap(year_ff);
   assign leap_tgt = is_leap(target_ff);
   assign month_ok = (req_ff.month_in >= MONTH_FIRST) && (req_ff.month_in <= MONTH_LAST);

   // Operand for the current step
   always_comb begin
      case (cmd.op)
         OP_SUB_YEAR, OP_ADD_YEAR: operand = SECS_YEAR + (leap_cur ? SECS_DAY : 32'd0);
         OP_SUB_MONTH:  operand = month_len_secs(month_ff, leap_cur);
         OP_SUB_DAY:    operand = SECS_DAY;
         OP_SUB_HOUR:   operand = SECS_HOUR;
         OP_SUB_MIN:    operand = SECS_MIN;
         OP_ADD_MONTH:  operand = month_start_secs(req_ff.month_in)
                                  + ((leap_tgt && (req_ff.month_in > MONTH_FEB)) ?
                                     SECS_DAY : 32'd0);
         OP_ADD_DAY:    operand = 32'({25'd0, req_ff.day_in} * SECS_DAY) - SECS_DAY;
         OP_ADD_HOUR:   operand = 32'({25'd0, req_ff.hour_in} * SECS_HOUR);
         OP_ADD_MINSEC: operand = 32'({25'd0, req_ff.minute_in} * SECS_MIN)
                                  + {25'd0, req_ff.second_in};
         default:       operand = 32'd0;
      endcase
   end

   assign ge = (acc_ff >= operand);

   // Loop condition: step taken this cycle
   always_comb begin
      case (cmd.op)
         OP_SUB_YEAR, OP_SUB_DAY, OP_SUB_HOUR, OP_SUB_MIN: more = ge;
         OP_SUB_MONTH: more = ge && (month_ff != MONTH_LAST);
         OP_ADD_YEAR:  more = (year_ff < target_ff);
         default:      more = 1'b0;
      endcase
   end

   assign status.is_build = (req_ff.command == CMD_BUILD);
   assign status.month_ok = month_ok;
   assign status.more     = more;

   always_comb begin
      acc_in    = acc_ff;
      year_in   = year_ff;
      target_in = target_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      if (cmd.load_req) begin
         acc_in    = (req_word.command == CMD_BUILD) ? 32'd0 : req_word.epoch_in;
         year_in   = EPOCH_YEAR;
         target_in = (req_word.year_in < YY_PIVOT) ? BASE_20XX + {5'd0, req_word.year_in}
                                                    : BASE_19XX + {5'd0, req_word.year_in};
         month_in  = MONTH_FIRST;
         day_in    = 5'd1;
         hour_in   = 5'd0;
         minute_in = 6'd0;
      end else begin
         case (cmd.op)
            OP_SUB_YEAR: begin
               if (more) begin
                  acc_in  = acc_ff - operand;
                  year_in = year_ff + 12'd1;
               end
            end
            OP_SUB_MONTH: begin
               if (more) begin
                  acc_in   = acc_ff - operand;
                  month_in = month_ff + 4'd1;
               end
            end
            OP_SUB_DAY: begin
               if (more) begin
                  acc_in = acc_ff - operand;
                  day_in = day_ff + 5'd1;
               end
            end
            OP_SUB_HOUR: begin
               if (more) begin
                  acc_in  = acc_ff - operand;
                  hour_in = hour_ff + 5'd1;
               end
            end
            OP_SUB_MIN: begin
               if (more) begin
                  acc_in    = acc_ff - operand;
                  minute_in = minute_ff + 6'd1;
               end
            end
            OP_ADD_YEAR: begin
               if (more) begin
                  acc_in  = acc_ff + operand;
                  year_in = year_ff + 12'd1;
               end
            end
            OP_ADD_MONTH, OP_ADD_DAY, OP_ADD_HOUR, OP_ADD_MINSEC: begin
               acc_in = acc_ff + operand;
            end
            default: begin
            end
         endcase
      end
   end

   // Response word
   always_comb begin
      rsp_in = '0;
      if (req_ff.command == CMD_BUILD) begin
         rsp_in.epoch_out   = month_ok ? acc_ff : 32'd0;
         rsp_in.month_error = !month_ok;
      end else begin
         rsp_in.year_out   = year_ff;
         rsp_in.month_out  = month_ff;
         rsp_in.day_out    = day_ff;
         rsp_in.hour_out   = hour_ff;
         rsp_in.minute_out = minute_ff;
         rsp_in.second_out = acc_ff[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req_word;
      if (cmd.load_rsp) rsp_ff <= rsp_in;
      acc_ff    <= acc_in;
      year_ff   <= year_in;
      target_ff <= target_in;
      month_ff  <= month_in;
      day_ff    <= day_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
   end

   assign rsp_word = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/core/epoch_calendar_converter_core.sv
// Unix time <-> Gregorian calendar converter, one word in, one word out.
// Command 0 splits epoch seconds into year, month, day, hour, minute and
// second; command 1 builds epoch seconds from a two-digit year (below 70 is
// 20xx) and the other fields, summed modulo 2^32; a month outside 1..12 sets
// month_error and gives epoch_out zero. One word is worked on at a time by a
// single 32-bit add/subtract accumulator stepped by the controller, one year
// (in a split also a month, day, hour or minute) per cycle; a bad month skips
// the build loops. req_ready rises again once the result is loaded; the
// result register holds the response word until taken, so the next request
// can run meanwhile. Depends on ecc_pkg, ecc_ctrl and ecc_dp.
`timescale 1ns / 1ps
`default_nettype none

module epoch_calendar_converter_core (
   input  logic                 clock,
   input  logic                 reset,
   // request word
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ecc_pkg::ecc_req_type req_word,
   // response word
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ecc_pkg::ecc_rsp_type rsp_word
);
   import ecc_pkg::*;

   ecc_cmd_type    cmd;
   ecc_status_type status;

   // Controller: walks the year, month, day, hour and minute loops
   ecc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: accumulator, counters, request and response registers
   ecc_dp u_dp (
      .clock    (clock),
      .req_word (req_word),
      .cmd      (cmd),
      .status   (status),
      .rsp_word (rsp_word)
   );

endmodule

`default_nettype wire

// File: rtl/core/ecc_checker.sv
// Port-level checks for the epoch calendar converter, bound to the top level.
// Depends on ecc_pkg and epoch_calendar_converter_core.
`timescale 1ns / 1ps
`default_nettype none

module ecc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input ecc_pkg::ecc_req_type req_word,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input ecc_pkg::ecc_rsp_type rsp_word
);
   import ecc_pkg::*;

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   // one word at a time: busy right after acceptance
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // a month error never carries an epoch value or a year
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.month_error |->
         rsp_word.epoch_out == 32'd0 && rsp_word.year_out == 12'd0)
      else $error("month error with non-zero result");

   // a split result is a proper calendar date and time
   a_split_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.year_out != 12'd0 |->
         rsp_word.month_out >= MONTH_FIRST && rsp_word.month_out <= MONTH_LAST &&
         rsp_word.day_out != 5'd0 && rsp_word.hour_out < 5'd24 &&
         rsp_word.minute_out < 6'd60 && rsp_word.second_out < 6'd60 &&
         rsp_word.epoch_out == 32'd0 && !rsp_word.month_error)
      else $error("calendar result out of range");

endmodule

bind epoch_calendar_converter_core ecc_checker u_checker (.*);

`default_nettype wire

// File: test/tb_epoch_calendar_converter_core.sv
// Self-checking testbench for epoch_calendar_converter_core: split and build
// words checked against an in-bench calendar model, with random flow control.
// Depends on ecc_pkg and the RTL of the converter.
`timescale 1ns / 1ps

module tb_epoch_calendar_converter_core;
   import ecc_pkg::*;

   localparam int unsigned DAY_SECS    = 86400;
   localparam int unsigned HOUR_SECS   = 3600;
   localparam int unsigned MINUTE_SECS = 60;
   localparam int HOLD_OFF_CYCLES = 600;   // long receiver stall, fills the block
   localparam int DRAIN_CYCLES    = 300;   // margin for the slowest split word
   localparam int WATCHDOG_LIMIT  = 5000;  // cycles with no word moving on either side
   localparam int RANDOM_WORDS    = 460;
   localparam int PRESSURE_WORDS  = 20;
   localparam int REQ_BITS        = $bits(ecc_req_type);

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   ecc_req_type req_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   ecc_rsp_type rsp_word;

   ecc_rsp_type due_words[$];     // predicted response words, oldest first
   int          fail_count = 0;
   int          burst_left = 0;
   logic        hold_off_request = 1'b0;
   int          hold_left = 0;
   int          stall_phase = 0;
   rx_mode_type stall_mode = RX_ALWAYS;
   logic [7:0]  stall_pattern = 8'b1101_0110;

   epoch_calendar_converter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- calendar model

   function automatic bit gregorian_leap(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
      case (m)
         2:           return leap ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   // epoch seconds -> calendar fields
   function automatic ecc_rsp_type split_seconds(input logic [31:0] t);
      ecc_rsp_type r;
      int unsigned days, rem, year, month;
      r = '0;
      days = t / DAY_SECS;
      rem = t % DAY_SECS;
      year = 1970;
      while (days >= 365 + gregorian_leap(year)) begin
         days -= 365 + gregorian_leap(year);
         year++;
      end
      month = 1;
      while (month < 12 && days >= days_in_month(month, gregorian_leap(year))) begin
         days -= days_in_month(month, gregorian_leap(year));
         month++;
      end
      r.year_out   = year[11:0];
      r.month_out  = month[3:0];
      r.day_out    = days[4:0] + 5'd1;
      r.hour_out   = 5'(rem / HOUR_SECS);
      r.minute_out = 6'((rem % HOUR_SECS) / MINUTE_SECS);
      r.second_out = 6'(rem % MINUTE_SECS);
      return r;
   endfunction

   // calendar fields -> epoch seconds, modulo 2^32
   function automatic ecc_rsp_type assemble_seconds(input ecc_req_type w);
      ecc_rsp_type     r;
      longint unsigned total;
      int unsigned     year, y, m;
      r = '0;
      if (w.month_in < MONTH_FIRST || w.month_in > MONTH_LAST) begin
         r.month_error = 1'b1;
         return r;
      end
      year = (w.year_in < YY_PIVOT) ? 2000 + w.year_in : 1900 + w.year_in;
      total = 0;
      for (y = 1970; y < year; y++)
         total += (365 + gregorian_leap(y)) * DAY_SECS;
      for (m = 1; m < w.month_in; m++)
         total += days_in_month(m, gregorian_leap(year)) * DAY_SECS;
      total += 64'(w.day_in) * DAY_SECS;
      total -= DAY_SECS;   // day is one-based; day 0 wraps below zero
      total += 64'(w.hour_in) * HOUR_SECS + 64'(w.minute_in) * MINUTE_SECS
               + 64'(w.second_in);
      r.epoch_out = total[31:0];
      return r;
   endfunction

   function automatic ecc_rsp_type convert_time(input ecc_req_type w);
      return (w.command == CMD_SPLIT) ? split_seconds(w.epoch_in) : assemble_seconds(w);
   endfunction

   // ---------------------------------------------------------------- word builders

   // unused fields carry junk so that ignoring them is checked too
   function automatic ecc_req_type split_word(input logic [31:0] t);
      ecc_req_type w;
      w = REQ_BITS'({$urandom(), $urandom(), $urandom()});
      w.command = CMD_SPLIT;
      w.epoch_in = t;
      return w;
   endfunction

   function automatic ecc_req_type build_word(input int yy, input int mm, input int dd,
                                              input int hh, input int mi, input int ss);
      ecc_req_type w;
      w.command   = CMD_BUILD;
      w.epoch_in  = $urandom();
      w.year_in   = 7'(yy);
      w.month_in  = 4'(mm);
      w.day_in    = 7'(dd);
      w.hour_in   = 7'(hh);
      w.minute_in = 7'(mi);
      w.second_in = 7'(ss);
      return w;
   endfunction

   function automatic ecc_req_type random_request();
      ecc_req_type w;
      int unsigned day_index;
      w = REQ_BITS'({$urandom(), $urandom(), $urandom()});
      if (w.command == CMD_SPLIT) begin
         case ($urandom_range(0, 2))
            0: ;   // whole 32-bit range as drawn
            1: begin
               // first or last second of a random day
               day_index = $urandom_range(0, 49709);
               w.epoch_in = day_index * DAY_SECS
                            + ($urandom_range(0, 1) ? DAY_SECS - 1 : 0);
            end
            default: w.epoch_in = $urandom_range(0, 200_000_000);
         endcase
      end else begin
         // mostly well-formed dates, the rest left at full field range
         if ($urandom_range(0, 7) != 0) w.month_in = 4'($urandom_range(1, 12));
         if ($urandom_range(0, 3) != 0) w.year_in = 7'($urandom_range(0, 99));
         if ($urandom_range(0, 3) != 0) begin
            w.day_in    = 7'($urandom_range(1, 31));
            w.hour_in   = 7'($urandom_range(0, 23));
            w.minute_in = 7'($urandom_range(0, 59));
            w.second_in = 7'($urandom_range(0, 59));
         end
      end
      return w;
   endfunction

   // ---------------------------------------------------------------- request side

   // Offers one word, bursty with random gaps; valid stays high between words
   // of a burst, so it is only ever dropped ahead of a gap.
   task automatic send_word(input ecc_req_type w);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 350) : $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      due_words.push_back(convert_time(w));
   endtask

   // ---------------------------------------------------------------- response side

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endtask

   task automatic check_response(input ecc_rsp_type got);
      ecc_rsp_type want;
      if (due_words.size() == 0) begin
         $error("response word with nothing outstanding: %h", got);
         fail_count++;
      end else begin
         want = due_words.pop_front();
         compare_field("epoch_out",   want.epoch_out,        got.epoch_out);
         compare_field("year_out",    32'(want.year_out),    32'(got.year_out));
         compare_field("month_out",   32'(want.month_out),   32'(got.month_out));
         compare_field("day_out",     32'(want.day_out),     32'(got.day_out));
         compare_field("hour_out",    32'(want.hour_out),    32'(got.hour_out));
         compare_field("minute_out",  32'(want.minute_out),  32'(got.minute_out));
         compare_field("second_out",  32'(want.second_out),  32'(got.second_out));
         compare_field("month_error", 32'(want.month_error), 32'(got.month_error));
      end
   endtask

   // Checks each word taken, then picks the next ready level. A hold-off request
   // overrides for a while the stall mode, redrawn at a zero low byte of stall_phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_response(rsp_word);
         stall_phase++;
         if (stall_phase % 256 == 0) stall_mode = rx_mode_type'($urandom_range(0, 3));
         stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_off_request) begin
            hold_off_request <= 1'b0;
            hold_left = HOLD_OFF_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            case (stall_mode)
               RX_ALWAYS:  rsp_ready <= 1'b1;
               RX_RANDOM:  rsp_ready <= 1'($urandom_range(0, 1));
               RX_PATTERN: rsp_ready <= stall_pattern[0];
               default:    rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   initial begin : watchdog
      int idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------- tests

   // Field extremes, leap-year boundaries, wrap-around and bad months.
   task automatic test_directed();
      send_word(split_word(32'd0));
      send_word(split_word(32'hFFFF_FFFF));          // 2106, top of the range
      send_word(split_word(32'd86399));
      send_word(split_word(32'd86400));
      send_word(split_word(32'd94694399));           // last second of 1972, a leap year
      send_word(split_word(32'd946684799));          // last second of 1999
      send_word(split_word(32'd951782400));          // 29 Feb 2000
      send_word(split_word(32'd951868800));          // 1 Mar 2000
      send_word(split_word(32'd4107542399));         // 28 Feb 2100, not a leap year
      send_word(split_word(32'd4107542400));         // 1 Mar 2100
      send_word(build_word(70, 1, 1, 0, 0, 0));      // epoch itself
      send_word(build_word(69, 12, 31, 23, 59, 59)); // last two-digit year, 2069
      send_word(build_word(0, 2, 29, 12, 30, 45));
      send_word(build_word(0, 3, 1, 0, 0, 0));
      send_word(build_word(72, 3, 1, 0, 0, 0));
      send_word(build_word(100, 3, 1, 0, 0, 0));     // three-digit year counts as 1900+
      send_word(build_word(127, 12, 31, 23, 59, 59));
      send_word(build_word(70, 1, 0, 0, 0, 0));      // day zero wraps modulo 2^32
      send_word(build_word(69, 12, 127, 127, 127, 127));
      send_word(build_word(0, 0, 0, 0, 0, 0));       // month zero
      send_word(build_word(99, 13, 1, 0, 0, 0));
      send_word(build_word(127, 15, 127, 127, 127, 127));
   endtask

   task automatic test_random_conversions();
      repeat (RANDOM_WORDS) send_word(random_request());
   endtask

   // Receiver holds off while words keep coming, so the block backs up.
   task automatic test_backpressure();
      hold_off_request <= 1'b1;
      repeat (PRESSURE_WORDS) send_word(random_request());
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random_conversions();
      req_valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
